// ----- rtl/core/ffha_pkg.sv -----
// ---------------------------------------------------------------------------
// ffha_pkg: shared definitions for the first-fit heap allocator
// heap geometry, header tags, status codes and header memory types
// ---------------------------------------------------------------------------
package ffha_pkg;

	// heap geometry
	localparam int HEAP_BYTES   = 4096;
	localparam int HEADER_BYTES = 8;

	// address / size width and field width of the request ports
	localparam int AW = $clog2(HEAP_BYTES);
	localparam int FW = 12;

	// operand width of the shared adder and its sum width (two carry bits)
	localparam int OW = (AW > FW) ? AW : FW;
	localparam int SW = OW + 2;

	localparam logic [SW-1:0] HDR_S      = SW'(HEADER_BYTES);
	localparam logic [SW-1:0] HEAP_END_S = SW'(HEAP_BYTES);
	localparam logic [SW-1:0] HEAP_LAST_S = SW'(HEAP_BYTES - 1);

	localparam logic [AW-1:0] INIT_SIZE = AW'(HEAP_BYTES - HEADER_BYTES - 1);
	localparam logic [AW-1:0] SIZE_MAX  = AW'(HEAP_BYTES - 1);

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// header tags
	typedef logic [1:0] tag_t;
	localparam tag_t TAG_NONE = 2'd0;
	localparam tag_t TAG_FREE = 2'd1;
	localparam tag_t TAG_USED = 2'd2;

	// result status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_ZERO     = 3'd1;
	localparam status_t ST_NOSPACE  = 3'd2;
	localparam status_t ST_NULL     = 3'd3;
	localparam status_t ST_RANGE    = 3'd4;
	localparam status_t ST_NOTALLOC = 3'd5;

	// one block header as kept in the header memory
	typedef struct packed {
		tag_t          tag;
		logic [AW-1:0] size;
	} hdr_t;

	// header memory write request
	typedef struct packed {
		logic          en;
		logic [AW-1:0] addr;
		hdr_t          data;
	} hdr_wr_t;

endpackage

// ----- rtl/core/first_fit_heap_allocator.sv -----
// allocate: each header on the walk is read, then evaluated; a split writes the tail header
// free: bad addresses skip the header reads; a used block absorbs a following free block
// one request at a time; the single read port of the header memory paces the walk
// throughput: a new request is taken in the cycle after the previous result is registered
// after reset a clearing pass over all HEAP_BYTES header words initializes the header memory
// arst_n clears the sequencer and the output valid; stall stays high during the pass
// ---------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit heap manager
// walks the in-band header chain to allocate, splits oversized blocks,
// frees blocks with a merge into a following free block
// ---------------------------------------------------------------------------
module first_fit_heap_allocator (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     cmd,
	input  logic [ffha_pkg::FW-1:0]  req_size,
	input  logic [ffha_pkg::FW-1:0]  free_addr,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output ffha_pkg::status_t        status,
	output logic [ffha_pkg::FW-1:0]  data_addr
);
	import ffha_pkg::*;

	// sequencer states
	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_AL_RD    = 4'd2;
	localparam logic [3:0] S_AL_EV    = 4'd3;
	localparam logic [3:0] S_AL_SPLIT = 4'd4;
	localparam logic [3:0] S_FR_RD    = 4'd5;
	localparam logic [3:0] S_FR_EV    = 4'd6;
	localparam logic [3:0] S_FR_RDN   = 4'd7;
	localparam logic [3:0] S_FR_EVN   = 4'd8;
	localparam logic [3:0] S_FR_CLR   = 4'd9;
	localparam logic [3:0] S_RESP     = 4'd10;

	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;         // clearing pass pointer

	logic [AW-1:0] p_q;           // current header offset
	logic [AW-1:0] n_q;           // next header offset on a free
	logic [AW-1:0] q_q;           // split tail header offset
	logic [AW-1:0] tail_q;        // split tail size
	logic [AW-1:0] szp_q;         // size of the block being freed
	logic [FW-1:0] req_q;         // requested size

	status_t       res_status_q;  // result waiting for the output register
	logic [FW-1:0] res_addr_q;

	logic          out_valid_q;
	status_t       status_q;
	logic [FW-1:0] data_addr_q;

	// header memory
	hdr_wr_t       hdr_wr;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	hdr_t          rd_data;

	// shared adder
	logic [OW-1:0] ua;
	logic [OW-1:0] ub;
	logic [SW-1:0] usum;
	logic          u_over;
	logic          u_last;

	logic          fit;
	logic          split_ok;
	logic [AW-1:0] tail_size;
	logic [AW-1:0] merged_size;
	logic [FW-1:0] data_of_p;
	logic [SW-1:0] fa_ext;
	logic [SW-1:0] fp;
	logic          fa_bad;
	logic          out_load;

	ffha_hdr_mem u_mem (
		.clk     (clk),
		.wr      (hdr_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ffha_add_unit u_add (
		.a       (ua),
		.b       (ub),
		.sum     (usum),
		.over    (u_over),
		.at_last (u_last)
	);

	// block fits the request: free and large enough
	assign fit = (rd_data.tag == TAG_FREE) && (SW'(rd_data.size) >= SW'(req_q));

	// adder operands: walk step, split offset, next block offset, merged size
	always_comb begin
		ua = OW'(p_q);
		ub = OW'(rd_data.size);
		if (state_q == S_AL_EV && fit) begin
			ub = OW'(req_q);
		end
		if (state_q == S_FR_EVN) begin
			ua = OW'(szp_q);
		end
	end

	// split only with room for a header and the tail header inside the heap
	assign split_ok    = (SW'(rd_data.size) > (SW'(req_q) + HDR_S)) && !u_last;
	assign tail_size   = AW'(SW'(rd_data.size) - SW'(req_q) - HDR_S);
	assign merged_size = u_over ? SIZE_MAX : AW'(usum);
	assign data_of_p   = FW'(SW'(p_q) + HDR_S);

	// free address checks: null, below the first data byte, header past the heap
	assign fa_ext = SW'(free_addr);
	assign fp     = fa_ext - HDR_S;
	assign fa_bad = (free_addr == '0) || (fa_ext < HDR_S) || (fp > HEAP_LAST_S);

	// header reads
	assign rd_en   = (state_q == S_AL_RD) || (state_q == S_FR_RD) || (state_q == S_FR_RDN);
	assign rd_addr = (state_q == S_FR_RDN) ? n_q : p_q;

	// header writes
	always_comb begin
		hdr_wr = '0;
		unique case (state_q)
			S_CLEAR: begin
				hdr_wr.en   = 1'b1;
				hdr_wr.addr = clr_q;
				if (clr_q == '0) begin
					hdr_wr.data = '{tag: TAG_FREE, size: INIT_SIZE};
				end else begin
					hdr_wr.data = '{tag: TAG_NONE, size: '0};
				end
			end
			S_AL_EV: begin
				// mark the chosen block used, shrink it on a split
				if (fit) begin
					hdr_wr.en   = 1'b1;
					hdr_wr.addr = p_q;
					hdr_wr.data = '{tag: TAG_USED,
						size: split_ok ? AW'(req_q) : rd_data.size};
				end
			end
			S_AL_SPLIT: begin
				hdr_wr.en   = 1'b1;
				hdr_wr.addr = q_q;
				hdr_wr.data = '{tag: TAG_FREE, size: tail_q};
			end
			S_FR_EV: begin
				if (rd_data.tag == TAG_USED) begin
					hdr_wr.en   = 1'b1;
					hdr_wr.addr = p_q;
					hdr_wr.data = '{tag: TAG_FREE, size: rd_data.size};
				end
			end
			S_FR_EVN: begin
				// absorb the following free block
				if (rd_data.tag == TAG_FREE) begin
					hdr_wr.en   = 1'b1;
					hdr_wr.addr = p_q;
					hdr_wr.data = '{tag: TAG_FREE, size: merged_size};
				end
			end
			S_FR_CLR: begin
				// retire the absorbed header, its size word is left as is
				hdr_wr.en   = 1'b1;
				hdr_wr.addr = n_q;
				hdr_wr.data = '{tag: TAG_NONE, size: rd_data.size};
			end
			default: begin
				hdr_wr = '0;
			end
		endcase
	end

	// output register takes the result when empty or being drained
	assign out_load = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						if (cmd == CMD_FREE) begin
							state_q <= fa_bad ? S_RESP : S_FR_RD;
						end else begin
							state_q <= (req_size == '0) ? S_RESP : S_AL_RD;
						end
					end
				end
				S_AL_RD: begin
					state_q <= S_AL_EV;
				end
				S_AL_EV: begin
					if (fit) begin
						state_q <= split_ok ? S_AL_SPLIT : S_RESP;
					end else begin
						// walk ends once the next header lies past the heap
						state_q <= u_over ? S_RESP : S_AL_RD;
					end
				end
				S_AL_SPLIT: begin
					state_q <= S_RESP;
				end
				S_FR_RD: begin
					state_q <= S_FR_EV;
				end
				S_FR_EV: begin
					if (rd_data.tag != TAG_USED || u_over) begin
						state_q <= S_RESP;
					end else begin
						state_q <= S_FR_RDN;
					end
				end
				S_FR_RDN: begin
					state_q <= S_FR_EVN;
				end
				S_FR_EVN: begin
					state_q <= (rd_data.tag == TAG_FREE) ? S_FR_CLR : S_RESP;
				end
				S_FR_CLR: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q      <= req_size;
				p_q        <= AW'(fp);
				res_addr_q <= '0;
				// error code in case the request ends right here
				if (cmd == CMD_ALLOC) begin
					res_status_q <= ST_ZERO;
				end else if (free_addr == '0) begin
					res_status_q <= ST_NULL;
				end else begin
					res_status_q <= ST_RANGE;
				end
				if (cmd == CMD_ALLOC) begin
					p_q <= '0;
				end
			end
			S_AL_EV: begin
				if (fit) begin
					res_status_q <= ST_OK;
					res_addr_q   <= data_of_p;
					q_q          <= AW'(usum);
					tail_q       <= tail_size;
				end else begin
					res_status_q <= ST_NOSPACE;
					p_q          <= AW'(usum);
				end
			end
			S_FR_EV: begin
				szp_q        <= rd_data.size;
				n_q          <= AW'(usum);
				res_status_q <= (rd_data.tag == TAG_USED) ? ST_OK : ST_NOTALLOC;
			end
			default: begin
			end
		endcase

		if (out_load) begin
			status_q    <= res_status_q;
			data_addr_q <= res_addr_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_addr = data_addr_q;

`ifndef SYNTHESIS
	// every error result carries a zero address
	a_err_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (data_addr == '0))
		else $error("error result with nonzero data address");

	// status codes stay within the defined set
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_NOTALLOC))
		else $error("undefined status code");

	// no header write while waiting for a request
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !hdr_wr.en)
		else $error("header write while idle");

	// the clearing pass neither takes requests nor shows results
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (in_stall && !out_valid))
		else $error("activity during clearing pass");
`endif

endmodule

// ----- rtl/core/ffha_hdr_mem.sv -----
// ---------------------------------------------------------------------------
// ffha_hdr_mem: header memory
// one header word per heap byte offset, one write and one registered read
// ---------------------------------------------------------------------------
module ffha_hdr_mem (
	input  logic            clk,
	input  ffha_pkg::hdr_wr_t wr,
	input  logic            rd_en,
	input  logic [ffha_pkg::AW-1:0] rd_addr,
	output ffha_pkg::hdr_t  rd_data
);
	import ffha_pkg::*;

	hdr_t mem [HEAP_BYTES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/ffha_add_unit.sv -----
// ---------------------------------------------------------------------------
// ffha_add_unit: shared header adder
// forms a + header + b and flags sums that reach the heap end
// ---------------------------------------------------------------------------
module ffha_add_unit (
	input  logic [ffha_pkg::OW-1:0] a,
	input  logic [ffha_pkg::OW-1:0] b,
	output logic [ffha_pkg::SW-1:0] sum,
	output logic                    over,
	output logic                    at_last
);
	import ffha_pkg::*;

	assign sum     = SW'(a) + HDR_S + SW'(b);
	// sum lies past the last heap byte
	assign over    = (sum >= HEAP_END_S);
	// sum lies at or past the last heap byte
	assign at_last = (sum >= HEAP_LAST_S);

endmodule

// ----- bench/first_fit_heap_allocator_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_test: self-checking bench for the heap allocator
// drives allocate and free requests, keeps its own image of the block
// headers to predict each status and data offset, and compares in order
// ---------------------------------------------------------------------------

import ffha_pkg::*;

// expected results of the heap, built from a private copy of the headers
class heap_scoreboard;
	tag_t          hdr_tag  [HEAP_BYTES];
	logic [AW-1:0] hdr_size [HEAP_BYTES];
	status_t       exp_status_q [$];
	logic [FW-1:0] exp_addr_q [$];
	int            errors;

	function new();
		errors = 0;
		foreach (hdr_tag[i]) begin
			hdr_tag[i]  = TAG_NONE;
			hdr_size[i] = '0;
		end
		// one free block spans the whole heap after reset
		hdr_tag[0]  = TAG_FREE;
		hdr_size[0] = INIT_SIZE;
	endfunction

	function int pending();
		return exp_status_q.size();
	endfunction

	task report(input string msg);
		if (errors < 50)
			$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// first-fit walk from offset 0, split off the tail when it fits
	function status_t alloc_block(input int req, output int data);
		int p;
		int blk;
		data = 0;
		if (req == 0)
			return ST_ZERO;
		p = 0;
		while (p <= HEAP_BYTES - 1) begin
			blk = hdr_size[p];
			if (hdr_tag[p] == TAG_FREE && blk >= req) begin
				hdr_tag[p] = TAG_USED;
				data = p + HEADER_BYTES;
				if (blk > req + HEADER_BYTES && data + req < HEAP_BYTES - 1) begin
					hdr_size[p] = AW'(req);
					hdr_tag[data + req]  = TAG_FREE;
					hdr_size[data + req] = AW'(blk - req - HEADER_BYTES);
				end
				return ST_OK;
			end
			p += HEADER_BYTES + blk;
		end
		return ST_NOSPACE;
	endfunction

	// address checks, then release with a merge into a free successor
	function status_t free_block(input int a);
		int p;
		int n;
		int merged;
		if (a == 0)
			return ST_NULL;
		if (a < HEADER_BYTES)
			return ST_RANGE;
		p = a - HEADER_BYTES;
		if (p > HEAP_BYTES - 1)
			return ST_RANGE;
		if (hdr_tag[p] != TAG_USED)
			return ST_NOTALLOC;
		hdr_tag[p] = TAG_FREE;
		n = p + HEADER_BYTES + hdr_size[p];
		if (n < HEAP_BYTES && hdr_tag[n] == TAG_FREE) begin
			merged = hdr_size[p] + HEADER_BYTES + hdr_size[n];
			if (merged > HEAP_BYTES - 1)
				merged = HEAP_BYTES - 1;
			hdr_size[p] = AW'(merged);
			hdr_tag[n]  = TAG_NONE;
		end
		return ST_OK;
	endfunction

	// called once per accepted request; hands the prediction back to the driver
	function void note_request(input logic c, input logic [FW-1:0] sz,
			input logic [FW-1:0] fa, output status_t st, output logic [FW-1:0] da);
		int data;
		data = 0;
		if (c == CMD_ALLOC)
			st = alloc_block(int'(sz), data);
		else
			st = free_block(int'(fa));
		da = FW'(data);
		exp_status_q.push_back(st);
		exp_addr_q.push_back(da);
	endfunction

	task check_result(input status_t st, input logic [FW-1:0] da);
		status_t       want_st;
		logic [FW-1:0] want_da;
		if (exp_status_q.size() == 0) begin
			report($sformatf("result with nothing expected: status %0d addr %0d", st, da));
			return;
		end
		want_st = exp_status_q.pop_front();
		want_da = exp_addr_q.pop_front();
		if (st !== want_st)
			report($sformatf("status %0d, expected %0d", st, want_st));
		if (da !== want_da)
			report($sformatf("data_addr %0d, expected %0d", da, want_da));
	endtask
endclass

module first_fit_heap_allocator_test;

	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int RANDOM_ITEMS = 200;   // per idling phase, four phases
	localparam int LIVE_MAX     = 48;    // bound on outstanding blocks keeps walks short

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic          cmd = CMD_ALLOC;
	logic [FW-1:0] req_size = '0;
	logic [FW-1:0] free_addr = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	status_t       status;
	logic [FW-1:0] data_addr;

	heap_scoreboard sb;

	int cycle_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	// data offsets the bench believes are allocated, for well-formed frees
	logic [FW-1:0] live_addrs [$];
	logic [FW-1:0] last_freed = '0;

	first_fit_heap_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.req_size  (req_size),
		.free_addr (free_addr),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.data_addr (data_addr)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// result monitor: a result is taken when valid is high and stall low
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_result(status, data_addr);
	end

	// hang guard, counts from time zero so the clearing pass is included
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// one request: optional idle gap, then hold until accepted
	// entered and left just after a falling edge
	task automatic send_request(input logic c, input logic [FW-1:0] sz,
			input logic [FW-1:0] fa, output status_t st, output logic [FW-1:0] da);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		req_size  <= sz;
		free_addr <= fa;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		sb.note_request(c, sz, fa, st, da);
		@(negedge clk);
	endtask

	// allocate with a random don't-care free_addr; track the granted block
	task automatic alloc_req(input logic [FW-1:0] sz);
		status_t       st;
		logic [FW-1:0] da;
		send_request(CMD_ALLOC, sz, FW'($urandom_range(0, 4095)), st, da);
		if (st == ST_OK)
			live_addrs.push_back(da);
	endtask

	// free with a random don't-care req_size
	task automatic free_req(input logic [FW-1:0] fa);
		status_t       st;
		logic [FW-1:0] da;
		send_request(CMD_FREE, FW'($urandom_range(0, 4095)), fa, st, da);
		last_freed = fa;
	endtask

	// sender holds off until every outstanding result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// mostly small blocks, some medium, a few over the full field range
	function automatic logic [FW-1:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return FW'($urandom_range(1, 64));
		else if (r < 92)
			return FW'($urandom_range(1, 512));
		return FW'($urandom_range(0, 4095));
	endfunction

	task automatic random_request();
		int r;
		int idx;
		logic [FW-1:0] fa;
		r = $urandom_range(99);
		if (live_addrs.size() > 0 && (r < 35 || live_addrs.size() > LIVE_MAX)) begin
			// well-formed free of an outstanding block
			idx = $urandom_range(0, live_addrs.size() - 1);
			fa = live_addrs[idx];
			live_addrs.delete(idx);
			free_req(fa);
		end else if (r < 80) begin
			alloc_req(pick_size());
		end else if (r < 86) begin
			// arbitrary address across the whole field
			free_req(FW'($urandom_range(0, 4095)));
		end else if (r < 90) begin
			// double free
			free_req(last_freed);
		end else if (r < 93) begin
			alloc_req('0);
		end else if (r < 96) begin
			// null, below-header and other low addresses up to HEADER_BYTES + 7
			free_req(FW'($urandom_range(0, HEADER_BYTES + 7)));
		end else begin
			// address near a live block but not on its data offset
			if (live_addrs.size() > 0)
				fa = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
			else
				fa = FW'(HEADER_BYTES);
			free_req(fa + FW'($urandom_range(1, 15)));
		end
	endtask

	initial begin
		int snd_pct [4];
		int rcv_pct [4];
		sb = new();
		snd_pct = '{0, 77, 0, 15};
		rcv_pct = '{0, 0, 77, 15};

		// reset once; the block then clears its header memory with stall high
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, no idling
		alloc_req('0);                     // zero-size request
		free_req('0);                      // null pointer
		free_req(FW'(1));                  // below header size
		free_req(FW'(HEADER_BYTES - 1));
		free_req(FW'(HEADER_BYTES));       // block exists but is free
		free_req(FW'(4095));               // no header there
		alloc_req(FW'(4095));              // larger than the heap
		alloc_req(FW'(INIT_SIZE + 1));     // one byte too many
		alloc_req(INIT_SIZE);              // exact fit of the whole heap
		alloc_req(FW'(1));                 // heap full
		free_req(FW'(HEADER_BYTES));       // successor is past the chain end, no merge
		free_req(FW'(HEADER_BYTES));       // double free
		alloc_req(FW'(INIT_SIZE - HEADER_BYTES)); // near fit, whole block taken
		free_req(FW'(HEADER_BYTES));
		alloc_req(FW'(1));                 // split, tail header right after one byte
		alloc_req(FW'(INIT_SIZE - 1 - HEADER_BYTES)); // tail taken exactly
		alloc_req(FW'(1));                 // heap full again
		free_req(FW'(HEADER_BYTES));       // successor in use, no merge
		free_req(FW'(2 * HEADER_BYTES + 1));
		free_req(FW'(HEADER_BYTES));       // merge with the free tail
		alloc_req(FW'(100));
		alloc_req(FW'(2048));
		free_req(FW'(HEADER_BYTES));
		free_req(FW'(2 * HEADER_BYTES + 100)); // merge into the split-off tail
		drain();
		live_addrs.delete();

		// random part in four idling phases; drain between phases
		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct    = snd_pct[ph];
			receiver_stall_pct = rcv_pct[ph];
			for (int i = 0; i < RANDOM_ITEMS; i++)
				random_request();
			drain();
		end

		// quiet tail to catch stray results
		receiver_stall_pct = 0;
		repeat (64) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/ffha_pkg.sv
rtl/core/ffha_hdr_mem.sv
rtl/core/ffha_add_unit.sv
rtl/core/first_fit_heap_allocator.sv
bench/first_fit_heap_allocator_test.sv
